>>> rtl/mlc_pkg.sv
// Package for the motion light controller: widths, register indexes,
// timing constants and the drive scaling function.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package mlc_pkg;

  // Level scale of the ambient sensor and of the PWM output.
  localparam int unsigned LEVEL_FULL = 1023;
  localparam int unsigned PWM_MAX    = 1023;

  // Field widths.
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LEVEL_W = 10;
  localparam int unsigned RUN_W   = 8;
  localparam int unsigned HOLD_W  = 16;
  localparam int unsigned CLICK_W = 3;
  localparam int unsigned WIN_W   = 26;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;

  // Bit positions in the result word.
  localparam int unsigned OUT_DRIVE_POS = 0;
  localparam int unsigned OUT_LAMP_POS  = 10;
  localparam int unsigned OUT_LONG_POS  = 11;
  localparam int unsigned OUT_DIM_POS   = 12;
  localparam int unsigned OUT_HOLD_POS  = 13;
  localparam int unsigned OUT_LOW_POS   = 14;
  localparam int unsigned OUT_HIGH_POS  = 24;

  // Timing constants in milliseconds.
  localparam int unsigned SECOND_MS    = 1000;
  localparam int unsigned MINUTE_MS    = 60 * 1000;
  localparam int unsigned MODE_WAIT_MS = 2 * 60 * 1000;

  // Threshold widening step and ceiling (limit_high + step stays below 0.9 * LEVEL_FULL).
  localparam int unsigned WIDEN_STEP  = 10;
  localparam int unsigned WIDEN_LIMIT = LEVEL_FULL * 9;

  // Button press level: ambient above 0.95 * LEVEL_FULL.
  localparam int unsigned PRESS_LIMIT = LEVEL_FULL * 19;

  // Click counts that select a mode.
  localparam int unsigned CLICK_MAX = 7;
  localparam logic [CLICK_W-1:0] CLICKS_NORMAL = 3'd1;
  localparam logic [CLICK_W-1:0] CLICKS_LONG   = 3'd2;
  localparam logic [CLICK_W-1:0] CLICKS_DIM    = 3'd3;

  // Reset values of the configuration registers.
  localparam logic [LEVEL_W-1:0] BRIGHT_RST  = 10'd1023;
  localparam logic [LEVEL_W-1:0] DIM_RST     = 10'd300;
  localparam logic [LEVEL_W-1:0] LOW_RST     = 10'd200;
  localparam logic [LEVEL_W-1:0] HIGH_RST    = 10'd400;
  localparam logic [RUN_W-1:0]   RUN_RST     = 8'd2;
  localparam logic [HOLD_W-1:0]  HOLD_RST    = 16'd45;
  localparam logic [LEVEL_W-1:0] LONG_RST    = 10'd5;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHT_LEVEL        = 3'd0,
    REG_DIM_LEVEL           = 3'd1,
    REG_THRESHOLD_LOW_INIT  = 3'd2,
    REG_THRESHOLD_HIGH_INIT = 3'd3,
    REG_MOTION_RUN_NEEDED   = 3'd4,
    REG_HOLD_SECONDS        = 3'd5,
    REG_LONG_HOLD_MINUTES   = 3'd6
  } cfg_idx_t;

  // Drive scaling lvl * PWM_MAX / LEVEL_FULL as one multiply by a reciprocal.
  // With a 31-bit shift the quotient is exact for every 20-bit numerator.
  localparam int unsigned DRV_SHIFT = 31;
  localparam int unsigned DRV_MUL_W = 35;
  localparam int unsigned DRV_PROD_W = DRV_MUL_W + LEVEL_W;
  localparam longint unsigned DRV_RECIP =
      ((64'd1 << DRV_SHIFT) + LEVEL_FULL - 1) / LEVEL_FULL;
  localparam longint unsigned DRV_MUL = DRV_RECIP * PWM_MAX;

  function automatic logic [LEVEL_W-1:0] scale_drive(input logic [LEVEL_W-1:0] lvl);
    logic [LEVEL_W-1:0]    clamped;
    logic [DRV_PROD_W-1:0] prod;
    clamped = (lvl > LEVEL_W'(LEVEL_FULL)) ? LEVEL_W'(LEVEL_FULL) : lvl;
    prod = DRV_PROD_W'(clamped) * DRV_PROD_W'(DRV_MUL);
    return prod[DRV_SHIFT +: LEVEL_W];
  endfunction

endpackage

>>> rtl/motion_light_controller.sv
// Motion light controller top level: input register, per-tick update logic,
// result register and configuration registers. Depends on mlc_pkg.
`timescale 1ns / 1ps

// One tick word in gives one result word out. A word accepted on in_* is
// held in an input register and is worked off by a single pass of
// compare-and-update logic into the result register, so the block takes one
// word per cycle while out_tready is high, and a result word is shown on
// out_* once that pass has written the result register. The input side keeps
// accepting while a result waits on out_*; only a full input register with a
// stalled result holds in_tready low. Configuration writes on cfg_* are always
// taken and should be made while no tick is in flight.
module motion_light_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  // Tick words. tdata: now_ms[31:0], motion_high[32], ambient_level[42:33].
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mlc_pkg::IN_DATA_W-1:0]     in_tdata,
  // Result words. tdata: drive_level[9:0], lamp_on[10], long_mode[11],
  // dim_mode[12], hold_request[13], limit_low_now[23:14], limit_high_now[33:24].
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mlc_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mlc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mlc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned TW = mlc_pkg::TIME_W;
  localparam int unsigned LW = mlc_pkg::LEVEL_W;

  // Handshake and pipeline control.
  logic in_valid_r, out_valid_r;
  logic advance, in_accept, cfg_write;

  // Input register.
  logic [TW-1:0] in_now_r;
  logic          in_motion_r;
  logic [LW-1:0] in_amb_r;

  // Configuration registers.
  logic [LW-1:0]                  bright_r, dim_r;
  logic [mlc_pkg::RUN_W-1:0]      run_need_r;
  logic [mlc_pkg::HOLD_W-1:0]     hold_sec_r;
  logic [LW-1:0]                  long_min_r;

  // Controller state and next values.
  logic [mlc_pkg::RUN_W-1:0]   motion_run_r, motion_run_nxt;
  logic [TW-1:0]               last_motion_r, last_motion_nxt;
  logic [TW-1:0]               bright_motion_r, bright_motion_nxt;
  logic                        lamp_r, lamp_nxt;
  logic [LW-1:0]               active_limit_r, active_limit_nxt;
  logic [LW-1:0]               limit_low_r, limit_low_nxt;
  logic [LW-1:0]               limit_high_r, limit_high_nxt;
  logic [1:0]                  fast_toggles_r, fast_toggles_nxt;
  logic [TW-1:0]               last_toggle_r, last_toggle_nxt;
  logic [TW-1:0]               mode_set_r, mode_set_nxt;
  logic [TW-1:0]               press_start_r, press_start_nxt;
  logic [TW-1:0]               last_click_r, last_click_nxt;
  logic [mlc_pkg::CLICK_W-1:0] click_count_r, click_count_nxt;
  logic                        long_r, long_nxt;
  logic                        dimf_r, dimf_nxt;

  // Result register.
  logic [mlc_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Per-tick working values.
  logic                        stuck, onset, lamp_req, pressed, hold_req;
  logic [mlc_pkg::WIN_W-1:0]   win_norm, win_long, window;
  logic [TW:0]                 now_x;
  logic [LW-1:0]               drive;
  logic [1:0]                  toggles_inc;
  logic [LW:0]                 high_plus;
  logic [TW-1:0]               press_age, mode_age;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Hold windows in milliseconds for normal and long mode.
  assign win_norm = mlc_pkg::WIN_W'(hold_sec_r) * mlc_pkg::WIN_W'(mlc_pkg::SECOND_MS);
  assign win_long = mlc_pkg::WIN_W'(long_min_r) * mlc_pkg::WIN_W'(mlc_pkg::MINUTE_MS);
  assign now_x    = {1'b0, in_now_r};

  // Next state and result for the tick in the input register.
  always_comb begin
    // Motion qualification.
    stuck = in_motion_r && (motion_run_r == {mlc_pkg::RUN_W{1'b1}});
    if (!in_motion_r) begin
      motion_run_nxt = '0;
    end else if (motion_run_r == {mlc_pkg::RUN_W{1'b1}}) begin
      motion_run_nxt = motion_run_r;
    end else begin
      motion_run_nxt = motion_run_r + 1'b1;
    end
    onset = (motion_run_nxt == run_need_r) && !stuck;
    last_motion_nxt   = (motion_run_nxt >= run_need_r) ? in_now_r : last_motion_r;
    bright_motion_nxt = bright_motion_r;
    if (!in_motion_r && (bright_motion_r != '0)) begin
      bright_motion_nxt = '0;
      last_motion_nxt   = '0;
    end

    // Lamp request from ambient level and the hold window.
    window   = long_r ? win_long : win_norm;
    lamp_req = 1'b0;
    if (in_amb_r > active_limit_r) begin
      if (onset) begin
        bright_motion_nxt = in_now_r;
      end
    end else begin
      lamp_req = (last_motion_nxt != '0) && (bright_motion_nxt == '0) &&
                 (now_x < ({1'b0, last_motion_nxt} + (TW+1)'(window)));
    end

    // Lamp switching, hysteresis and threshold widening on fast toggles.
    drive = lamp_req ? mlc_pkg::scale_drive(dimf_r ? dim_r : bright_r) : '0;
    active_limit_nxt = lamp_req ? limit_high_r : limit_low_r;
    mode_set_nxt = mode_set_r;
    if (lamp_r && !lamp_req && (long_r || dimf_r)) begin
      mode_set_nxt = in_now_r;
    end
    lamp_nxt         = lamp_r;
    fast_toggles_nxt = fast_toggles_r;
    last_toggle_nxt  = last_toggle_r;
    limit_low_nxt    = limit_low_r;
    limit_high_nxt   = limit_high_r;
    toggles_inc      = fast_toggles_r + 2'd1;
    high_plus        = {1'b0, limit_high_r} + (LW+1)'(mlc_pkg::WIDEN_STEP);
    if (lamp_r != lamp_req) begin
      lamp_nxt = lamp_req;
      if (now_x < ({1'b0, last_toggle_r} + (TW+1)'(mlc_pkg::SECOND_MS))) begin
        if (toggles_inc >= 2'd2) begin
          if ((15'(high_plus) * 15'd10) < 15'(mlc_pkg::WIDEN_LIMIT)) begin
            limit_high_nxt = high_plus[LW-1:0];
          end else if (limit_low_r >= LW'(mlc_pkg::WIDEN_STEP)) begin
            limit_low_nxt = limit_low_r - LW'(mlc_pkg::WIDEN_STEP);
          end
          fast_toggles_nxt = '0;
        end else begin
          fast_toggles_nxt = toggles_inc;
        end
      end else begin
        fast_toggles_nxt = '0;
      end
      last_toggle_nxt = in_now_r;
    end

    // Button decoding on a very bright ambient level.
    pressed         = (15'(in_amb_r) * 15'd20) > 15'(mlc_pkg::PRESS_LIMIT);
    press_age       = in_now_r - press_start_r;
    press_start_nxt = press_start_r;
    last_click_nxt  = last_click_r;
    click_count_nxt = click_count_r;
    long_nxt        = long_r;
    dimf_nxt        = dimf_r;
    hold_req        = 1'b0;
    if (pressed) begin
      if (press_start_r == '0) begin
        press_start_nxt = in_now_r;
      end else if (now_x > ({1'b0, press_start_r} + (TW+1)'(mlc_pkg::SECOND_MS))) begin
        hold_req = 1'b1;
      end
    end else if (press_start_r != '0) begin
      if (press_age < TW'(mlc_pkg::SECOND_MS)) begin
        if (click_count_r < mlc_pkg::CLICK_W'(mlc_pkg::CLICK_MAX)) begin
          click_count_nxt = click_count_r + 1'b1;
        end
        last_click_nxt = in_now_r;
      end
      press_start_nxt = '0;
    end else if ((last_click_r != '0) &&
                 (now_x > ({1'b0, last_click_r} + (TW+1)'(mlc_pkg::SECOND_MS)))) begin
      case (click_count_r)
        mlc_pkg::CLICKS_NORMAL: begin
          long_nxt = 1'b0;
          dimf_nxt = 1'b0;
        end
        mlc_pkg::CLICKS_LONG: long_nxt = 1'b1;
        mlc_pkg::CLICKS_DIM:  dimf_nxt = 1'b1;
        default: ;
      endcase
      mode_set_nxt    = (long_nxt || dimf_nxt) ? in_now_r : '0;
      last_click_nxt  = '0;
      click_count_nxt = '0;
    end

    // Modes fall back to normal a while after the lamp went off.
    mode_age = in_now_r - mode_set_nxt;
    if (!lamp_nxt && (mode_set_nxt != '0) && (in_now_r > mode_set_nxt) &&
        (mode_age > TW'(mlc_pkg::MODE_WAIT_MS))) begin
      long_nxt     = 1'b0;
      dimf_nxt     = 1'b0;
      mode_set_nxt = '0;
    end

    // Result word.
    out_data_nxt = '0;
    out_data_nxt[mlc_pkg::OUT_DRIVE_POS +: LW] = drive;
    out_data_nxt[mlc_pkg::OUT_LAMP_POS]        = lamp_nxt;
    out_data_nxt[mlc_pkg::OUT_LONG_POS]        = long_nxt;
    out_data_nxt[mlc_pkg::OUT_DIM_POS]         = dimf_nxt;
    out_data_nxt[mlc_pkg::OUT_HOLD_POS]        = hold_req;
    out_data_nxt[mlc_pkg::OUT_LOW_POS +: LW]   = limit_low_nxt;
    out_data_nxt[mlc_pkg::OUT_HIGH_POS +: LW]  = limit_high_nxt;
  end

  // Handshake flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_now_r    <= in_tdata[TW-1:0];
      in_motion_r <= in_tdata[TW];
      in_amb_r    <= in_tdata[TW+1 +: LW];
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Configuration registers and controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r        <= mlc_pkg::BRIGHT_RST;
      dim_r           <= mlc_pkg::DIM_RST;
      run_need_r      <= mlc_pkg::RUN_RST;
      hold_sec_r      <= mlc_pkg::HOLD_RST;
      long_min_r      <= mlc_pkg::LONG_RST;
      motion_run_r    <= '0;
      last_motion_r   <= '0;
      bright_motion_r <= '0;
      lamp_r          <= 1'b0;
      active_limit_r  <= mlc_pkg::LOW_RST;
      limit_low_r     <= mlc_pkg::LOW_RST;
      limit_high_r    <= mlc_pkg::HIGH_RST;
      fast_toggles_r  <= '0;
      last_toggle_r   <= '0;
      mode_set_r      <= '0;
      press_start_r   <= '0;
      last_click_r    <= '0;
      click_count_r   <= '0;
      long_r          <= 1'b0;
      dimf_r          <= 1'b0;
    end else if (cfg_write) begin
      case (mlc_pkg::cfg_idx_t'(cfg_index))
        mlc_pkg::REG_BRIGHT_LEVEL: bright_r <= cfg_data[LW-1:0];
        mlc_pkg::REG_DIM_LEVEL:    dim_r    <= cfg_data[LW-1:0];
        mlc_pkg::REG_THRESHOLD_LOW_INIT: begin
          limit_low_r    <= cfg_data[LW-1:0];
          active_limit_r <= cfg_data[LW-1:0];
        end
        mlc_pkg::REG_THRESHOLD_HIGH_INIT: limit_high_r <= cfg_data[LW-1:0];
        mlc_pkg::REG_MOTION_RUN_NEEDED:   run_need_r   <= cfg_data[mlc_pkg::RUN_W-1:0];
        mlc_pkg::REG_HOLD_SECONDS:        hold_sec_r   <= cfg_data;
        mlc_pkg::REG_LONG_HOLD_MINUTES:   long_min_r   <= cfg_data[LW-1:0];
        default: ;
      endcase
    end else if (advance) begin
      motion_run_r    <= motion_run_nxt;
      last_motion_r   <= last_motion_nxt;
      bright_motion_r <= bright_motion_nxt;
      lamp_r          <= lamp_nxt;
      active_limit_r  <= active_limit_nxt;
      limit_low_r     <= limit_low_nxt;
      limit_high_r    <= limit_high_nxt;
      fast_toggles_r  <= fast_toggles_nxt;
      last_toggle_r   <= last_toggle_nxt;
      mode_set_r      <= mode_set_nxt;
      press_start_r   <= press_start_nxt;
      last_click_r    <= last_click_nxt;
      click_count_r   <= click_count_nxt;
      long_r          <= long_nxt;
      dimf_r          <= dimf_nxt;
    end
  end

endmodule

>>> rtl/mlc_checker.sv
// Port-level checks for the motion light controller, bound to the top level.
// Depends on mlc_pkg for the result word layout.
`timescale 1ns / 1ps

module mlc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [mlc_pkg::OUT_DATA_W-1:0] out_tdata
);

  // No result word is shown right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // With the result register empty the input side is never blocked.
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while result register empty");

  // The lamp drive is zero whenever the lamp is off.
  a_drive_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[mlc_pkg::OUT_LAMP_POS] |->
      out_tdata[mlc_pkg::OUT_DRIVE_POS +: mlc_pkg::LEVEL_W] == '0)
    else $error("drive level nonzero with lamp off");

endmodule

bind motion_light_controller mlc_checker u_mlc_checker (.*);
